// File: rtl/aabb_por_pkg.sv
// ----------------------------------------------------------------------------
// aabb_por_pkg
// Shared types and constants for the box push-out resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_por_pkg;

   localparam int POS_W      = 32;
   localparam int HALF_W     = 31;
   localparam int MARGIN_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam int CALC_W     = 36;

   localparam int COORD_BITS_DEFAULT = 32;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_COLLIDE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_HALF_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_HALF_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_HALF_Z = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PUSH_MARGIN   = 2'd3;

   localparam logic [HALF_W-1:0]   PLAYER_HALF_X_RST = 31'd32768;
   localparam logic [HALF_W-1:0]   PLAYER_HALF_Y_RST = 31'd65536;
   localparam logic [HALF_W-1:0]   PLAYER_HALF_Z_RST = 31'd32768;
   localparam logic [MARGIN_W-1:0] PUSH_MARGIN_RST   = 16'd66;

   typedef struct packed {
      logic                    op;
      logic signed [POS_W-1:0] center_x;
      logic signed [POS_W-1:0] center_y;
      logic signed [POS_W-1:0] center_z;
      logic [HALF_W-1:0]       half_x;
      logic [HALF_W-1:0]       half_y;
      logic [HALF_W-1:0]       half_z;
      logic                    is_solid;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    hit;
      logic                    any_hit;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [HALF_W-1:0]   player_half_x;
      logic [HALF_W-1:0]   player_half_y;
      logic [HALF_W-1:0]   player_half_z;
      logic [MARGIN_W-1:0] push_margin;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/aabb_por_csr.sv
// ----------------------------------------------------------------------------
// aabb_por_csr
// Configuration registers: player half-extents and push margin.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_por_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [aabb_por_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [aabb_por_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output aabb_por_pkg::cfg_type                     cfg
);

   aabb_por_pkg::cfg_type cfg_ff;
   aabb_por_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            aabb_por_pkg::CSR_PLAYER_HALF_X: begin
               cfg_in.player_half_x = csr_wdata;
            end
            aabb_por_pkg::CSR_PLAYER_HALF_Y: begin
               cfg_in.player_half_y = csr_wdata;
            end
            aabb_por_pkg::CSR_PLAYER_HALF_Z: begin
               cfg_in.player_half_z = csr_wdata;
            end
            aabb_por_pkg::CSR_PUSH_MARGIN: begin
               cfg_in.push_margin = csr_wdata[aabb_por_pkg::MARGIN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.player_half_x <= aabb_por_pkg::PLAYER_HALF_X_RST;
         cfg_ff.player_half_y <= aabb_por_pkg::PLAYER_HALF_Y_RST;
         cfg_ff.player_half_z <= aabb_por_pkg::PLAYER_HALF_Z_RST;
         cfg_ff.push_margin   <= aabb_por_pkg::PUSH_MARGIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/aabb_por_solve.sv
// ----------------------------------------------------------------------------
// aabb_por_solve
// Clamped start load, or overlap test, least-penetration axis and clamped
// push-out, for one transaction against the current player position.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_por_solve #(
   parameter int RANGE_BITS = 32
) (
   input  wire aabb_por_pkg::req_type          req,
   input  wire aabb_por_pkg::cfg_type          cfg,
   input  wire logic signed [RANGE_BITS-1:0]   pos_cur [3],
   output logic signed [RANGE_BITS-1:0]        pos_next [3],
   output logic                                hit,
   output logic                                sat
);

   localparam int W = aabb_por_pkg::CALC_W;
   localparam logic signed [W-1:0] POS_MAX = W'((64'sd1 <<< (RANGE_BITS - 1)) - 64'sd1);
   localparam logic signed [W-1:0] POS_MIN = -POS_MAX - W'(1);

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   function automatic logic signed [RANGE_BITS-1:0] clamp_val(input logic signed [W-1:0] v);
      logic signed [W-1:0] r;
      begin
         r = v;
         if (v > POS_MAX) begin
            r = POS_MAX;
         end else if (v < POS_MIN) begin
            r = POS_MIN;
         end
         clamp_val = r[RANGE_BITS-1:0];
      end
   endfunction

   function automatic logic out_of_range(input logic signed [W-1:0] v);
      out_of_range = (v > POS_MAX) || (v < POS_MIN);
   endfunction

   logic signed [W-1:0] c_w    [3];
   logic signed [W-1:0] h_w    [3];
   logic signed [W-1:0] p_w    [3];
   logic signed [W-1:0] ph_w   [3];
   logic signed [W-1:0] pmin_w [3];
   logic signed [W-1:0] pmax_w [3];
   logic signed [W-1:0] smin_w [3];
   logic signed [W-1:0] smax_w [3];
   logic signed [W-1:0] pen_w  [3];
   logic signed [W-1:0] pen_lo, pen_hi;
   logic [2:0]          ovl;
   logic [1:0]          ax;
   logic signed [W-1:0] extra;
   logic signed [W-1:0] target;

   always_comb begin
      c_w[0]  = W'(req.center_x);
      c_w[1]  = W'(req.center_y);
      c_w[2]  = W'(req.center_z);
      h_w[0]  = W'($signed({1'b0, req.half_x}));
      h_w[1]  = W'($signed({1'b0, req.half_y}));
      h_w[2]  = W'($signed({1'b0, req.half_z}));
      ph_w[0] = W'($signed({1'b0, cfg.player_half_x}));
      ph_w[1] = W'($signed({1'b0, cfg.player_half_y}));
      ph_w[2] = W'($signed({1'b0, cfg.player_half_z}));
      for (int a = 0; a < 3; a++) begin
         p_w[a]    = W'(pos_cur[a]);
         pmin_w[a] = p_w[a] - ph_w[a];
         pmax_w[a] = p_w[a] + ph_w[a];
         smin_w[a] = c_w[a] - h_w[a];
         smax_w[a] = c_w[a] + h_w[a];
         ovl[a]    = (pmin_w[a] <= smax_w[a]) && (pmax_w[a] >= smin_w[a]);
         pen_lo    = pmax_w[a] - smin_w[a];
         pen_hi    = smax_w[a] - pmin_w[a];
         pen_w[a]  = (pen_lo < pen_hi) ? pen_lo : pen_hi;
      end
   end

   always_comb begin
      priority if ((pen_w[1] <= pen_w[0]) && (pen_w[1] <= pen_w[2])) begin
         ax = AXIS_Y;
      end else if (pen_w[0] <= pen_w[2]) begin
         ax = AXIS_X;
      end else begin
         ax = AXIS_Z;
      end
   end

   always_comb begin
      extra  = ph_w[ax] + W'($signed({1'b0, cfg.push_margin}));
      target = (p_w[ax] > c_w[ax]) ? (smax_w[ax] + extra) : (smin_w[ax] - extra);
   end

   always_comb begin
      pos_next = pos_cur;
      hit      = 1'b0;
      sat      = 1'b0;
      if (req.op == aabb_por_pkg::OP_START) begin
         for (int a = 0; a < 3; a++) begin
            pos_next[a] = clamp_val(c_w[a]);
            sat         = sat | out_of_range(c_w[a]);
         end
      end else if (req.is_solid && (&ovl)) begin
         hit          = 1'b1;
         pos_next[ax] = clamp_val(target);
         sat          = out_of_range(target);
      end
   end

endmodule

`default_nettype wire

// File: rtl/aabb_por_pipe.sv
// ----------------------------------------------------------------------------
// aabb_por_pipe
// Input register, player state and result register with the handshake
// control that moves one transaction per cycle between them while results are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_por_pipe #(
   parameter int RANGE_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire aabb_por_pkg::req_type          req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output aabb_por_pkg::rsp_type               rsp_data,
   output aabb_por_pkg::req_type               cur_req,
   output logic signed [RANGE_BITS-1:0]        pos_cur [3],
   input  wire logic signed [RANGE_BITS-1:0]   pos_next [3],
   input  wire logic                           hit,
   input  wire logic                           sat
);

   logic                            in_valid_ff, in_valid_in;
   aabb_por_pkg::req_type           in_data_ff;
   logic                            out_valid_ff, out_valid_in;
   aabb_por_pkg::rsp_type           out_data_ff, out_data_in;
   logic signed [RANGE_BITS-1:0]    pos_ff [3];
   logic                            frame_hit_ff, frame_hit_in;
   logic                            req_accept;
   logic                            advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (in_data_ff.op == aabb_por_pkg::OP_START) begin
         frame_hit_in = 1'b0;
      end else begin
         frame_hit_in = frame_hit_ff | hit;
      end
      out_data_in.pos_x     = aabb_por_pkg::POS_W'(pos_next[0]);
      out_data_in.pos_y     = aabb_por_pkg::POS_W'(pos_next[1]);
      out_data_in.pos_z     = aabb_por_pkg::POS_W'(pos_next[2]);
      out_data_in.hit       = hit;
      out_data_in.any_hit   = frame_hit_in;
      out_data_in.saturated = sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         frame_hit_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            pos_ff[a] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            frame_hit_ff <= frame_hit_in;
            pos_ff       <= pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign cur_req   = in_data_ff;
   assign pos_cur   = pos_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// File: rtl/aabb_push_out_resolver.sv
// ----------------------------------------------------------------------------
// aabb_push_out_resolver
// Pushes a player box out of static boxes along the axis of least
// penetration. A start transaction loads the player centre and clears the
// frame hit flag; each collider transaction tests one box and returns the
// player position after it. One transaction is taken every cycle while
// results are taken; it passes through the input register, then the result
// register, and the player position registers, which each transaction reads
// and rewrites, set the rate. Positions are Q16.16 and clamp to a signed
// range of min(COORD_BITS, 32) bits. The user must see that configuration is
// written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_push_out_resolver #(
   parameter int COORD_BITS = aabb_por_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire aabb_por_pkg::req_type                req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output aabb_por_pkg::rsp_type                     rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [aabb_por_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [aabb_por_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int RANGE_BITS = (COORD_BITS > aabb_por_pkg::POS_W) ?
                               aabb_por_pkg::POS_W : COORD_BITS;

   aabb_por_pkg::cfg_type         cfg;
   aabb_por_pkg::req_type         cur_req;
   logic signed [RANGE_BITS-1:0]  pos_cur  [3];
   logic signed [RANGE_BITS-1:0]  pos_next [3];
   logic                          hit;
   logic                          sat;

   assign csr_ready = 1'b1;

   aabb_por_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aabb_por_solve #(
      .RANGE_BITS (RANGE_BITS)
   ) u_solve (
      .req      (cur_req),
      .cfg      (cfg),
      .pos_cur  (pos_cur),
      .pos_next (pos_next),
      .hit      (hit),
      .sat      (sat)
   );

   aabb_por_pipe #(
      .RANGE_BITS (RANGE_BITS)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cur_req   (cur_req),
      .pos_cur   (pos_cur),
      .pos_next  (pos_next),
      .hit       (hit),
      .sat       (sat)
   );

endmodule

`default_nettype wire

// File: tb/aabb_push_out_resolver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_push_out_resolver_tb
// Self-checking bench for the box push-out resolver. A short table of
// directed transactions covers the field extremes, the axis tie-breaks,
// touching boxes, clamping at both ends of the range and colliders seen
// before any frame start. Random frames follow under several register
// settings: a start transaction and a run of colliders placed near the
// player, with some noise. Both handshakes idle and stall at random. Every
// result is checked field by field against an in-bench model of the
// push-out, or against the expected value given in the table for fixed rows.
// ----------------------------------------------------------------------------

module aabb_push_out_resolver_tb;
   import aabb_por_pkg::*;

   localparam int      COORD_BITS  = COORD_BITS_DEFAULT;
   localparam int      LATENCY     = 2;
   localparam int      PHASES      = 6;
   localparam int      PHASE_ITEMS = 308;
   localparam longint  CYCLE_LIMIT = 1000000;
   localparam int      SPAN        = 32'h50000;

   localparam logic [HALF_W-1:0]   HMAX  = 31'h7FFF_FFFF;
   localparam logic signed [31:0]  P_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]  P_MIN = 32'sh8000_0000;

   typedef struct packed {
      req_type item;
      logic    fixed;
      rsp_type want;
   } stim_row;

   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // model state and register copies
   longint  player_at[3];
   bit      frame_struck;
   longint  cfg_half[3];
   longint  cfg_margin;

   rsp_type expected_pos_q[$];
   stim_row directed_rows[$];
   bit      row_fixed;
   rsp_type row_want;

   int      errors     = 0;
   int      items_in   = 0;
   int      pushes     = 0;
   int      clamps     = 0;
   int      csr_writes = 0;
   longint  cycle_count = 0;

   aabb_push_out_resolver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic longint limit_to_range(input longint v, inout bit clamped);
      longint hi;
      longint lo;
      int     rb;
      rb = (COORD_BITS > POS_W) ? POS_W : ((COORD_BITS < 2) ? 2 : COORD_BITS);
      hi = (longint'(1) << (rb - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clamped = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clamped = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic rsp_type resolve_push(input req_type r);
      longint  ctr[3];
      longint  ext[3];
      longint  lo_s[3];
      longint  hi_s[3];
      longint  depth[3];
      longint  lo_p;
      longint  hi_p;
      longint  target;
      bit      clamped;
      bit      struck;
      int      ax;
      rsp_type res;
      clamped = 1'b0;
      struck  = 1'b0;
      ctr[0] = r.center_x;
      ctr[1] = r.center_y;
      ctr[2] = r.center_z;
      ext[0] = r.half_x;
      ext[1] = r.half_y;
      ext[2] = r.half_z;
      if (r.op == OP_START) begin
         for (int a = 0; a < 3; a++) player_at[a] = limit_to_range(ctr[a], clamped);
         frame_struck = 1'b0;
      end else if (r.is_solid) begin
         struck = 1'b1;
         for (int a = 0; a < 3; a++) begin
            lo_p    = player_at[a] - cfg_half[a];
            hi_p    = player_at[a] + cfg_half[a];
            lo_s[a] = ctr[a] - ext[a];
            hi_s[a] = ctr[a] + ext[a];
            if (!(lo_p <= hi_s[a] && hi_p >= lo_s[a])) struck = 1'b0;
            depth[a] = (hi_p - lo_s[a] < hi_s[a] - lo_p) ? hi_p - lo_s[a] : hi_s[a] - lo_p;
         end
         if (struck) begin
            frame_struck = 1'b1;
            if (depth[1] <= depth[0] && depth[1] <= depth[2]) ax = 1;
            else if (depth[0] <= depth[2]) ax = 0;
            else ax = 2;
            if (player_at[ax] > ctr[ax]) target = hi_s[ax] + cfg_half[ax] + cfg_margin;
            else target = lo_s[ax] - cfg_half[ax] - cfg_margin;
            player_at[ax] = limit_to_range(target, clamped);
         end
      end
      res.pos_x     = 32'(player_at[0]);
      res.pos_y     = 32'(player_at[1]);
      res.pos_z     = 32'(player_at[2]);
      res.hit       = struck;
      res.any_hit   = frame_struck;
      res.saturated = clamped;
      return res;
   endfunction

   function automatic req_type mk_item(input logic op, input logic signed [31:0] x, y, z,
                                       input logic [HALF_W-1:0] hx, hy, hz,
                                       input logic solid);
      req_type r;
      r.op       = op;
      r.center_x = x;
      r.center_y = y;
      r.center_z = z;
      r.half_x   = hx;
      r.half_y   = hy;
      r.half_z   = hz;
      r.is_solid = solid;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic signed [31:0] x, y, z,
                                      input logic h, a, s);
      rsp_type r;
      r.pos_x     = x;
      r.pos_y     = y;
      r.pos_z     = z;
      r.hit       = h;
      r.any_hit   = a;
      r.saturated = s;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [HALF_W-1:0] pick_half();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 31'($urandom_range(0, 32'h30000));
      if (r < 85) return '0;
      if (r < 95) return 31'($urandom);
      return HMAX;
   endfunction

   function automatic logic signed [31:0] pick_coord(input longint base);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 32'(base + longint'($urandom_range(0, 2 * SPAN)) - SPAN);
      if (r < 90) return $urandom;
      return $urandom_range(0, 1) ? P_MAX : P_MIN;
   endfunction

   function automatic req_type near_collider(input longint base[3]);
      return mk_item(OP_COLLIDE, pick_coord(base[0]), pick_coord(base[1]),
                     pick_coord(base[2]), pick_half(), pick_half(), pick_half(),
                     $urandom_range(0, 99) < 85);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      if (errors <= 40)
         $display("[%0d] mismatch on %s: got %0d, want %0d", cycle_count, what, got, want);
   endtask

   task automatic add_row(input req_type item, input logic fixed, input rsp_type want);
      directed_rows.push_back('{item: item, fixed: fixed, want: want});
   endtask

   task automatic send_item(input req_type item, input bit fixed, input rsp_type want);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      row_fixed = fixed;
      row_want  = want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_req(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_quiet();
      pause_req(1);
      while (expected_pos_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PLAYER_HALF_X: cfg_half[0] = data;
         CSR_PLAYER_HALF_Y: cfg_half[1] = data;
         CSR_PLAYER_HALF_Z: cfg_half[2] = data;
         CSR_PUSH_MARGIN:   cfg_margin  = data[MARGIN_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] hx, hy, hz, margin_word);
      write_reg(CSR_PLAYER_HALF_X, hx);
      write_reg(CSR_PLAYER_HALF_Y, hy);
      write_reg(CSR_PLAYER_HALF_Z, hz);
      write_reg(CSR_PUSH_MARGIN, margin_word);
   endtask

   // result side: random back-pressure, occasionally a long clear stretch
   initial begin
      int n;
      forever begin
         n = pick_gap();
         if (n == 0) begin
            repeat (($urandom_range(0, 11) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24)) begin
               @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end else begin
            repeat (n) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type due;
      if (!reset) begin
         if (req_valid && req_ready) begin
            due = resolve_push(req_data);
            if (row_fixed) due = row_want;
            expected_pos_q.push_back(due);
            items_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pos_q.size() == 0) begin
               report_mismatch("result with no transaction pending", 0, 0);
            end else begin
               due = expected_pos_q.pop_front();
               if (rsp_data.pos_x !== due.pos_x)
                  report_mismatch("pos_x", rsp_data.pos_x, due.pos_x);
               if (rsp_data.pos_y !== due.pos_y)
                  report_mismatch("pos_y", rsp_data.pos_y, due.pos_y);
               if (rsp_data.pos_z !== due.pos_z)
                  report_mismatch("pos_z", rsp_data.pos_z, due.pos_z);
               if (rsp_data.hit !== due.hit)
                  report_mismatch("hit", rsp_data.hit, due.hit);
               if (rsp_data.any_hit !== due.any_hit)
                  report_mismatch("any_hit", rsp_data.any_hit, due.any_hit);
               if (rsp_data.saturated !== due.saturated)
                  report_mismatch("saturated", rsp_data.saturated, due.saturated);
               pushes += rsp_data.hit;
               clamps += rsp_data.saturated;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, expected_pos_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      req_type item;
      longint  base[3];
      int      sent;
      int      ncol;
      int      r;
      bit      calm;
      bit      broken;

      player_at    = '{0, 0, 0};
      frame_struck = 1'b0;
      cfg_half     = '{PLAYER_HALF_X_RST, PLAYER_HALF_Y_RST, PLAYER_HALF_Z_RST};
      cfg_margin   = PUSH_MARGIN_RST;
      row_fixed    = 1'b0;
      row_want     = '0;

      // reset register values throughout the table
      add_row(mk_item(OP_COLLIDE, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000, 1'b0), 1'b1,
              mk_rsp(0, 0, 0, 1'b0, 1'b0, 1'b0));
      // solid collider against the reset position
      add_row(mk_item(OP_COLLIDE, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000, 1'b1), 1'b0, '0);
      add_row(mk_item(OP_START, P_MIN, P_MAX, 0, HMAX, HMAX, HMAX, 1'b1), 1'b1,
              mk_rsp(P_MIN, P_MAX, 0, 1'b0, 1'b0, 1'b0));
      add_row(mk_item(OP_START, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, mk_rsp(0, 0, 0, 1'b0, 1'b0, 1'b0));
      // three-way tie goes to Y
      add_row(mk_item(OP_COLLIDE, 0, 0, 0, 31'h18000, 31'h10000, 31'h18000, 1'b1), 1'b0, '0);
      add_row(mk_item(OP_START, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, mk_rsp(0, 0, 0, 1'b0, 1'b0, 1'b0));
      // X and Z tie goes to X
      add_row(mk_item(OP_COLLIDE, 0, 0, 0, 31'h18000, 31'h20000, 31'h18000, 1'b1), 1'b0, '0);
      add_row(mk_item(OP_START, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, mk_rsp(0, 0, 0, 1'b0, 1'b0, 1'b0));
      add_row(mk_item(OP_COLLIDE, 0, 0, 0, 31'h18000, 31'h20000, 31'h10000, 1'b1), 1'b0, '0);
      add_row(mk_item(OP_START, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, mk_rsp(0, 0, 0, 1'b0, 1'b0, 1'b0));
      // faces touching: zero penetration still pushes
      add_row(mk_item(OP_COLLIDE, -32'sh18000, 0, 0, 31'h10000, 31'h100000, 31'h100000, 1'b1),
              1'b0, '0);
      add_row(mk_item(OP_START, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, mk_rsp(0, 0, 0, 1'b0, 1'b0, 1'b0));
      // one LSB short of touching
      add_row(mk_item(OP_COLLIDE, -32'sh18001, 0, 0, 31'h10000, 31'h100000, 31'h100000, 1'b1),
              1'b1, mk_rsp(0, 0, 0, 1'b0, 1'b0, 1'b0));
      add_row(mk_item(OP_COLLIDE, 0, 0, 0, HMAX, HMAX, HMAX, 1'b0), 1'b1,
              mk_rsp(0, 0, 0, 1'b0, 1'b0, 1'b0));
      add_row(mk_item(OP_COLLIDE, 0, 0, 0, HMAX, HMAX, HMAX, 1'b1), 1'b0, '0);
      // miss after a hit keeps the frame flag
      add_row(mk_item(OP_COLLIDE, P_MAX, P_MAX, P_MAX, 0, 0, 0, 1'b1), 1'b0, '0);
      add_row(mk_item(OP_START, 32'sh7FFF0000, 0, 0, 0, 0, 0, 1'b0), 1'b1,
              mk_rsp(32'sh7FFF0000, 0, 0, 1'b0, 1'b0, 1'b0));
      add_row(mk_item(OP_COLLIDE, 32'sh7FFE0000, 0, 0, 31'h20000, 31'h100000, 31'h100000, 1'b1),
              1'b1, mk_rsp(P_MAX, 0, 0, 1'b1, 1'b1, 1'b1));
      add_row(mk_item(OP_START, -32'sh7FFE0000, 0, 0, 0, 0, 0, 1'b0), 1'b1,
              mk_rsp(-32'sh7FFE0000, 0, 0, 1'b0, 1'b0, 1'b0));
      // equal centres go below the lower face
      add_row(mk_item(OP_COLLIDE, -32'sh7FFE0000, 0, 0, 31'h20000, 31'h100000, 31'h100000, 1'b1),
              1'b1, mk_rsp(P_MIN, 0, 0, 1'b1, 1'b1, 1'b1));
      add_row(mk_item(OP_START, P_MAX, P_MIN, P_MAX, 0, 0, 0, 1'b0), 1'b1,
              mk_rsp(P_MAX, P_MIN, P_MAX, 1'b0, 1'b0, 1'b0));
      add_row(mk_item(OP_COLLIDE, P_MIN, P_MAX, P_MIN, HMAX, HMAX, HMAX, 1'b1), 1'b0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
         pause_req(pick_gap());
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         case (p)
            0: set_config(PLAYER_HALF_X_RST, PLAYER_HALF_Y_RST, PLAYER_HALF_Z_RST,
                          PUSH_MARGIN_RST);
            1: set_config('0, '0, '0, '0);
            2: set_config(HMAX, HMAX, HMAX, {CSR_DATA_W{1'b1}});
            default: set_config(31'($urandom_range(0, 32'h40000)),
                                31'($urandom_range(0, 32'h40000)),
                                31'($urandom_range(0, 32'h40000)), 31'($urandom));
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            calm   = ($urandom_range(0, 7) == 0);
            broken = ($urandom_range(0, 19) == 0);
            r      = $urandom_range(0, 99);
            for (int a = 0; a < 3; a++) begin
               if (r < 70)
                  base[a] = longint'($urandom_range(0, 32'h200000)) - 32'h100000;
               else if (r < 85)
                  base[a] = longint'($signed($urandom));
               else
                  base[a] = ($urandom_range(0, 1) ? 1 : -1) *
                            (longint'(P_MAX) - longint'($urandom_range(0, 32'h40000)));
            end
            // start carries junk in the collider-only fields
            item = mk_item(OP_START, 32'(base[0]), 32'(base[1]), 32'(base[2]),
                           31'($urandom), 31'($urandom), 31'($urandom), 1'($urandom));
            send_item(item, 1'b0, '0);
            sent++;
            if (!calm) pause_req(pick_gap());
            ncol = $urandom_range(0, 10);
            for (int k = 0; k < ncol; k++) begin
               if (broken)
                  item = mk_item(1'($urandom), $urandom, $urandom, $urandom, 31'($urandom),
                                 31'($urandom), 31'($urandom), 1'($urandom));
               else
                  item = near_collider(base);
               send_item(item, 1'b0, '0);
               sent++;
               if (!calm) pause_req(pick_gap());
            end
         end
      end

      wait_quiet();
      if (expected_pos_q.size() != 0)
         report_mismatch("results never returned", expected_pos_q.size(), 0);

      $display("Covered %0d transactions over %0d register settings (%0d register writes).",
               items_in, PHASES + 1, csr_writes);
      $display("%0d results pushed the player out, %0d clamped a coordinate, %0d mismatches.",
               pushes, clamps, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/aabb_por_pkg.sv
rtl/aabb_por_csr.sv
rtl/aabb_por_solve.sv
rtl/aabb_por_pipe.sv
rtl/aabb_push_out_resolver.sv
tb/aabb_push_out_resolver_tb.sv
